@@ rtl/core/afb_pkg.sv @@
package afb_pkg;

    // One input transaction: start of frame or one parameter byte.
    typedef struct packed {
        logic        action;
        logic [63:0] dest_address;
        logic [7:0]  command_byte;
        logic [7:0]  param_count;
        logic [7:0]  param_byte;
    } t_in_item;

    // One output transaction: one byte of the serialized frame.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } t_out_item;

    // Action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_PARAM = 1'b1;

    // Fixed frame bytes
    localparam logic [7:0] SOF_BYTE   = 8'h7E;
    localparam logic [7:0] FRAME_TYPE = 8'h10;
    localparam logic [7:0] BCAST_HI   = 8'hFF;
    localparam logic [7:0] BCAST_LO   = 8'hFE;
    localparam logic [7:0] LEN_OFFSET = 8'd15;
    localparam logic [7:0] CKSUM_BASE = 8'hFF;

    // Byte positions within the emission of a start transaction
    localparam int unsigned POS_W = 5;
    localparam logic [POS_W-1:0] POS_SOF    = 5'd0;
    localparam logic [POS_W-1:0] POS_LEN_HI = 5'd1;
    localparam logic [POS_W-1:0] POS_LEN_LO = 5'd2;
    localparam logic [POS_W-1:0] POS_TYPE   = 5'd3;
    localparam logic [POS_W-1:0] POS_ID     = 5'd4;
    localparam logic [POS_W-1:0] POS_ADDR0  = 5'd5;
    localparam logic [POS_W-1:0] POS_ADDR7  = 5'd12;
    localparam logic [POS_W-1:0] POS_BC_HI  = 5'd13;
    localparam logic [POS_W-1:0] POS_BC_LO  = 5'd14;
    localparam logic [POS_W-1:0] POS_RADIUS = 5'd15;
    localparam logic [POS_W-1:0] POS_OPTS   = 5'd16;
    localparam logic [POS_W-1:0] POS_CMD    = 5'd17;
    localparam logic [POS_W-1:0] POS_CKSUM  = 5'd18;

    // Positions within the emission of a parameter transaction
    localparam logic [POS_W-1:0] POS_PARAM       = 5'd0;
    localparam logic [POS_W-1:0] POS_PARAM_CKSUM = 5'd1;

endpackage

@@ rtl/core/afb_frame_seq.sv @@
module afb_frame_seq #(
    parameter int unsigned MAX_PARAM_BYTES = 240
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  afb_pkg::t_in_item  i_item,
    input  logic               i_item_vld,
    input  logic               i_can_take,
    output logic               o_push,
    output afb_pkg::t_out_item o_out,
    output logic               o_done
);

    localparam logic [7:0] MAX_CNT = 8'(MAX_PARAM_BYTES);

    logic [afb_pkg::POS_W-1:0] r_idx, n_idx;
    logic                      r_open, n_open;
    logic [7:0]                r_rem, n_rem;
    logic [7:0]                r_sum, n_sum;

    logic [7:0] w_cnt;
    logic [7:0] w_rem_dec;
    logic [2:0] w_sel;
    logic [2:0] w_rev;
    logic [7:0] w_byte;
    logic       w_emit;
    logic       w_last;
    logic       w_fire;

    assign w_cnt     = (i_item.param_count > MAX_CNT) ? MAX_CNT : i_item.param_count;
    assign w_rem_dec = (r_rem != 8'd0) ? (r_rem - 8'd1) : 8'd0;
    assign w_sel     = 3'(r_idx - afb_pkg::POS_ADDR0);
    assign w_rev     = 3'd7 - w_sel;

    always_comb begin
        w_byte = 8'h00;
        w_emit = 1'b1;
        w_last = 1'b0;
        if (i_item.action == afb_pkg::ACT_START) begin
            case (r_idx)
                afb_pkg::POS_SOF:    w_byte = afb_pkg::SOF_BYTE;
                afb_pkg::POS_LEN_HI: w_byte = 8'h00;
                afb_pkg::POS_LEN_LO: w_byte = w_cnt + afb_pkg::LEN_OFFSET;
                afb_pkg::POS_TYPE:   w_byte = afb_pkg::FRAME_TYPE;
                afb_pkg::POS_ID:     w_byte = 8'h00;
                afb_pkg::POS_BC_HI:  w_byte = afb_pkg::BCAST_HI;
                afb_pkg::POS_BC_LO:  w_byte = afb_pkg::BCAST_LO;
                afb_pkg::POS_RADIUS: w_byte = 8'h00;
                afb_pkg::POS_OPTS:   w_byte = 8'h00;
                afb_pkg::POS_CMD: begin
                    w_byte = i_item.command_byte;
                    w_last = (w_cnt != 8'd0);
                end
                afb_pkg::POS_CKSUM: begin
                    w_byte = afb_pkg::CKSUM_BASE - r_sum;
                    w_last = 1'b1;
                end
                default: begin
                    // address bytes, MSB first
                    w_byte = i_item.dest_address[{w_rev, 3'b000} +: 8];
                end
            endcase
        end else if (!r_open) begin
            // stray parameter byte: swallowed
            w_emit = 1'b0;
        end else if (r_idx == afb_pkg::POS_PARAM) begin
            w_byte = i_item.param_byte;
            w_last = (w_rem_dec != 8'd0);
        end else begin
            w_byte = afb_pkg::CKSUM_BASE - r_sum;
            w_last = 1'b1;
        end
    end

    assign w_fire   = i_item_vld && w_emit && i_can_take;
    assign o_push   = w_fire;
    assign o_done   = i_item_vld && (!w_emit || (i_can_take && w_last));

    always_comb begin
        o_out.out_byte  = w_byte;
        o_out.frame_end = 1'b0;
        if (i_item.action == afb_pkg::ACT_START) begin
            o_out.frame_end = (r_idx == afb_pkg::POS_CKSUM);
        end else begin
            o_out.frame_end = (r_idx == afb_pkg::POS_PARAM_CKSUM);
        end
    end

    always_comb begin
        n_idx  = r_idx;
        n_open = r_open;
        n_rem  = r_rem;
        n_sum  = r_sum;
        if (w_fire) begin
            n_idx = w_last ? '0 : r_idx + 5'd1;
            if (o_out.frame_end) begin
                n_open = 1'b0;
                n_rem  = 8'd0;
                n_sum  = 8'd0;
            end else if (i_item.action == afb_pkg::ACT_START) begin
                if (r_idx == afb_pkg::POS_SOF) begin
                    n_sum = 8'd0;
                end else if (r_idx inside {[afb_pkg::POS_TYPE:afb_pkg::POS_CMD]}) begin
                    n_sum = r_sum + w_byte;
                end
                if (r_idx == afb_pkg::POS_CMD) begin
                    n_open = 1'b1;
                    n_rem  = w_cnt;
                end
            end else begin
                n_sum = r_sum + w_byte;
                n_rem = w_rem_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_open <= 1'b0;
            r_rem  <= 8'd0;
            r_sum  <= 8'd0;
        end else begin
            r_idx  <= n_idx;
            r_open <= n_open;
            r_rem  <= n_rem;
            r_sum  <= n_sum;
        end
    end

endmodule

@@ rtl/core/afb_out_reg.sv @@
module afb_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  afb_pkg::t_out_item i_data,
    output logic               o_can_take,
    output logic               o_valid,
    input  logic               i_ready,
    output afb_pkg::t_out_item o_data
);

    logic               r_vld;
    afb_pkg::t_out_item r_data;

    assign o_can_take = !r_vld || i_ready;
    assign o_valid    = r_vld;
    assign o_data     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_push) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_data;
        end
    end

endmodule

@@ rtl/core/api_transmit_frame_builder.sv @@
// The input transaction is first taken into the input holding register; its bytes then pass
// through the output register. A start transaction emits 18 bytes (19 with zero
// parameters); a parameter byte emits one byte, two when it is the last (checksum follows);
// a stray parameter byte is dropped with no output. One output byte per cycle at most.
// Reset: synchronous active-low i_rst_n clears all valid flags and frame state.
module api_transmit_frame_builder #(
    parameter int unsigned MAX_PARAM_BYTES = 240
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  afb_pkg::t_in_item  i_in_data,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output afb_pkg::t_out_item o_out_data
);

    // Input holding register. The held transaction stays here while the
    // sequencer walks its bytes; it frees up in the same cycle its last byte
    // goes into the output register, so a new transaction can be taken back
    // to back with no bubble.
    logic               r_item_vld;
    afb_pkg::t_in_item  r_item;

    // Sequencer <-> output register
    logic               w_push;
    logic               w_can_take;
    logic               w_done;
    afb_pkg::t_out_item w_seq_out;

    assign o_in_ready = !r_item_vld || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_item_vld <= 1'b1;
        end else if (w_done) begin
            r_item_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_data;
        end
    end

    // Byte sequencer: picks the byte for the current position, keeps the
    // running checksum, the open-frame flag and the parameter countdown.
    afb_frame_seq #(
        .MAX_PARAM_BYTES(MAX_PARAM_BYTES)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (r_item),
        .i_item_vld(r_item_vld),
        .i_can_take(w_can_take),
        .o_push    (w_push),
        .o_out     (w_seq_out),
        .o_done    (w_done)
    );

    // Output register: holds each byte for the downstream; its ready to the sequencer follows
    // the downstream ready combinationally, so it keeps accepting while the downstream is draining.
    afb_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_data    (w_seq_out),
        .o_can_take(w_can_take),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

endmodule
